// File: rtl/qld_pkg.sv
// ----------------------------------------------------------------------------
// qld_pkg: shared definitions for the quantized LUT distance engine
// Widths, table geometry, register decode and the control/status words
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package qld_pkg;

  localparam int DIM_MAX       = 256;
  localparam int CODES_PER_DIM = 16;
  localparam int CODE_W        = 4;
  localparam int DIM_W         = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int LUT_DEPTH     = DIM_MAX * CODES_PER_DIM;
  localparam int LUT_AW        = DIM_W + CODE_W;

  localparam int VAL_W   = 16;          // Q8.8 query / centroid
  localparam int LEN_W   = 9;
  localparam int STEP_W  = 16;
  localparam int CNT_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int DIFF_W  = 21;          // |qc| + 8*step fits in 20 bits
  localparam int MAG_W   = DIFF_W - 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int ENTRY_W = 32;
  localparam int ACC_W   = 48;

  localparam int OFFSET_SH = 3;         // code offset of 8 as a shift

  localparam logic [CODE_W-1:0]  CODE_LAST = CODE_W'(CODES_PER_DIM - 1);
  localparam logic [ENTRY_W-1:0] ENTRY_MAX = '1;
  localparam logic [ACC_W-1:0]   ACC_MAX   = '1;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic REG_LENGTH = 1'b0;
  localparam logic REG_STEP   = 1'b1;

  localparam logic [LEN_W-1:0]  LENGTH_RESET = LEN_W'(1);
  localparam logic [STEP_W-1:0] STEP_RESET   = STEP_W'(256);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0]  vector_length;
    logic [STEP_W-1:0] step_size;
  } cfg_t;

  typedef struct packed {
    logic                     command;
    logic [7:0]               dim_index;
    logic signed [VAL_W-1:0]  query_value;
    logic signed [VAL_W-1:0]  centroid_value;
    logic [BYTE_W-1:0]        code_byte;
  } in_word_t;

  typedef struct packed {
    logic [ACC_W-1:0] distance;
    logic             saturated;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic rd_lo;
    logic rd_hi;
    logic acc_hi;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_is_byte;
    logic in_load_ok;
    logic issue_last;
    logic last_byte;
    logic out_free;
    logic wr_pending;
  } st_t;

  function automatic logic [LUT_AW-1:0] lut_addr(input logic [DIM_W-1:0] dim,
                                                 input logic [CODE_W-1:0] code);
    lut_addr = {dim, code};
  endfunction

endpackage

`default_nettype wire

// File: rtl/qld_if.sv
// ----------------------------------------------------------------------------
// qld_if: stream channels of the distance engine
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface qld_in_if;
  import qld_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [7:0]              dim_index;
  logic signed [VAL_W-1:0] query_value;
  logic signed [VAL_W-1:0] centroid_value;
  logic [BYTE_W-1:0]       code_byte;

  modport source (output valid, command, dim_index, query_value, centroid_value,
                  code_byte, input ready);
  modport sink   (input valid, command, dim_index, query_value, centroid_value,
                  code_byte, output ready);
endinterface

interface qld_out_if;
  import qld_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACC_W-1:0] distance;
  logic             saturated;

  modport source (output valid, distance, saturated, input ready);
  modport sink   (input valid, distance, saturated, output ready);
endinterface

`default_nettype wire

// File: rtl/quantized_lut_distance_engine.sv
// ----------------------------------------------------------------------------
// quantized_lut_distance_engine: 4-bit code LUT squared-distance engine
// Load words (in-range dim): accept, 16 square issues, drain; one multiplier
//   feeds the single-port table store, one entry per cycle.
// Code bytes: accept, low read, high read, accumulate (two single-port reads);
//   the last byte of a vector adds an emit state that registers the result.
// Reset (rst, synchronous): clears controller, byte counter, accumulator,
//   flag and result valid; the table store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module quantized_lut_distance_engine (
  input  wire logic                        clk,
  input  wire logic                        rst,
  qld_in_if.sink                           items,
  qld_out_if.source                        results,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [qld_pkg::PADDR_W-1:0] paddr,
  input  wire logic [qld_pkg::PDATA_W-1:0] pwdata,
  output      logic [qld_pkg::PDATA_W-1:0] prdata,
  output      logic                        pready
);
  import qld_pkg::*;

  cfg_t      cfg;
  in_word_t  in_word;
  out_word_t out_word;
  cmd_t      cmd;
  st_t       st;
  logic      in_ready;
  logic      out_valid;

  assign in_word.command        = items.command;
  assign in_word.dim_index      = items.dim_index;
  assign in_word.query_value    = items.query_value;
  assign in_word.centroid_value = items.centroid_value;
  assign in_word.code_byte      = items.code_byte;
  assign items.ready            = in_ready;

  assign results.valid     = out_valid;
  assign results.distance  = out_word.distance;
  assign results.saturated = out_word.saturated;

  qld_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .st       (st),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  qld_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_word   (in_word),
    .cmd       (cmd),
    .out_ready (results.ready),
    .st        (st),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // table writes from the square pipe must never meet a lookup
  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    !(st.wr_pending && (cmd.rd_lo || cmd.rd_hi)))
    else $error("table write collides with lookup read");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> st.out_free)
    else $error("result emitted over an untaken word");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(cmd.emit))
    else $error("result valid without an emit");

endmodule

`default_nettype wire

// File: rtl/qld_ram.sv
// ----------------------------------------------------------------------------
// qld_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qld_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         addr,
  input  wire logic [WIDTH-1:0]                 wdata,
  output      logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: rtl/qld_regs.sv
// ----------------------------------------------------------------------------
// qld_regs: configuration registers
// APB-style write/read of vector length and code step size.
// ----------------------------------------------------------------------------
`default_nettype none

module qld_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [qld_pkg::PADDR_W-1:0] paddr,
  input  wire logic [qld_pkg::PDATA_W-1:0] pwdata,
  output      logic [qld_pkg::PDATA_W-1:0] prdata,
  output      logic                        pready,
  output      qld_pkg::cfg_t               cfg
);
  import qld_pkg::*;

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vector_length <= LENGTH_RESET;
      cfg.step_size     <= STEP_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LENGTH: cfg.vector_length <= pwdata[LEN_W-1:0];
        REG_STEP:   cfg.step_size     <= pwdata[STEP_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LENGTH: prdata = PDATA_W'(cfg.vector_length);
      REG_STEP:   prdata = PDATA_W'(cfg.step_size);
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/qld_dpath.sv
// ----------------------------------------------------------------------------
// qld_dpath: table build and accumulation datapath
// Square generator pipeline, lookup store, saturating accumulator and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qld_dpath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire qld_pkg::cfg_t       cfg,
  input  wire qld_pkg::in_word_t   in_word,
  input  wire qld_pkg::cmd_t       cmd,
  input  wire logic                out_ready,
  output      qld_pkg::st_t        st,
  output      logic                out_valid,
  output      qld_pkg::out_word_t  out_word
);
  import qld_pkg::*;

  // square generator
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        step_ext;
  logic signed [VAL_W:0]    qc;
  logic [CODE_W-1:0]        code_cnt;
  logic [DIM_W-1:0]         load_dim;
  logic [MAG_W-1:0]         mag;
  logic [LUT_AW-1:0]        mag_addr;
  logic                     mag_valid;
  logic [SQ_W-1:0]          sq;
  logic [LUT_AW-1:0]        sq_addr;
  logic                     sq_valid;
  logic [ENTRY_W-1:0]       wdata;

  // byte path
  logic [CNT_W-1:0]   byte_counter;
  logic [BYTE_W-1:0]  byte_reg;
  logic [CNT_W:0]     d0;
  logic [CNT_W:0]     d1;
  logic [LEN_W-1:0]   len_eff;
  logic [LEN_W:0]     nbytes;
  logic               use_lo;
  logic               use_hi;
  logic               last_byte;
  logic               use_lo_next;
  logic               use_hi_next;
  logic               last_next;
  logic [LUT_AW-1:0]  lo_addr;
  logic [LUT_AW-1:0]  hi_addr;
  logic [LUT_AW-1:0]  ram_addr;
  logic [ENTRY_W-1:0] rdata;

  logic [ACC_W-1:0]   accumulator;
  logic               overflow_seen;
  logic [ACC_W:0]     sum;
  logic               add_en;

  assign qc       = {in_word.query_value[VAL_W-1], in_word.query_value}
                  - {in_word.centroid_value[VAL_W-1], in_word.centroid_value};
  assign step_ext = DIFF_W'(cfg.step_size);

  always_ff @(posedge clk) begin
    if (cmd.accept && in_word.command == CMD_LOAD) begin
      // code 0 sits eight steps above q - c
      diff     <= DIFF_W'(qc) + (step_ext << OFFSET_SH);
      load_dim <= DIM_W'(in_word.dim_index);
      code_cnt <= '0;
    end else if (cmd.issue) begin
      diff     <= diff - step_ext;
      code_cnt <= code_cnt + 1'b1;
    end
    if (cmd.issue) begin
      mag      <= diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
      mag_addr <= lut_addr(load_dim, code_cnt);
    end
    sq      <= mag * mag;
    sq_addr <= mag_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
      sq_valid  <= 1'b0;
    end else begin
      mag_valid <= cmd.issue;
      sq_valid  <= mag_valid;
    end
  end

  // an oversized square is pinned at all-ones, which no true square hits
  assign wdata = (|sq[SQ_W-1:ENTRY_W]) ? ENTRY_MAX : sq[ENTRY_W-1:0];

  // byte bookkeeping, taken at accept time from the current counter
  always_comb begin
    if (cfg.vector_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(cfg.vector_length) > DIM_MAX) begin
      len_eff = LEN_W'(DIM_MAX);
    end else begin
      len_eff = cfg.vector_length;
    end
    nbytes      = ((LEN_W+1)'(len_eff) + 1'b1) >> 1;
    use_lo_next = (LEN_W+1)'({byte_counter, 1'b0}) < (LEN_W+1)'(len_eff);
    use_hi_next = (LEN_W+1)'({byte_counter, 1'b1}) < (LEN_W+1)'(len_eff);
    last_next   = ((LEN_W+1)'(byte_counter) + 1'b1) >= nbytes;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_word.command == CMD_BYTE) begin
      byte_reg  <= in_word.code_byte;
      use_lo    <= use_lo_next;
      use_hi    <= use_hi_next;
      last_byte <= last_next;
    end
  end

  assign d0      = {byte_counter, 1'b0};
  assign d1      = {byte_counter, 1'b1};
  assign lo_addr = lut_addr(DIM_W'(d0), byte_reg[CODE_W-1:0]);
  assign hi_addr = lut_addr(DIM_W'(d1), byte_reg[BYTE_W-1:CODE_W]);

  always_comb begin
    if (sq_valid) begin
      ram_addr = sq_addr;
    end else if (cmd.rd_hi) begin
      ram_addr = hi_addr;
    end else begin
      ram_addr = lo_addr;
    end
  end

  qld_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LUT_DEPTH)
  ) u_lut (
    .clk   (clk),
    .we    (sq_valid),
    .addr  (ram_addr[$clog2(LUT_DEPTH)-1:0]),
    .wdata (wdata),
    .rdata (rdata)
  );

  // low entry lands during rd_hi, high entry during acc_hi
  assign add_en = (cmd.rd_hi && use_lo) || (cmd.acc_hi && use_hi);
  assign sum    = {1'b0, accumulator} + (ACC_W+1)'(rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      overflow_seen <= 1'b0;
      byte_counter  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.emit) begin
        accumulator   <= '0;
        overflow_seen <= 1'b0;
      end else if (add_en) begin
        accumulator   <= sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
        overflow_seen <= overflow_seen || sum[ACC_W] || (rdata == ENTRY_MAX);
      end
      if (cmd.acc_hi) begin
        byte_counter <= last_byte ? '0 : byte_counter + 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word.distance  <= accumulator;
      out_word.saturated <= overflow_seen;
    end
  end

  assign st.in_is_byte = (in_word.command == CMD_BYTE);
  assign st.in_load_ok = 32'(in_word.dim_index) < DIM_MAX;
  assign st.issue_last = (code_cnt == CODE_LAST);
  assign st.last_byte  = last_byte;
  assign st.out_free   = !out_valid || out_ready;
  assign st.wr_pending = mag_valid || sq_valid;

endmodule

`default_nettype wire

// File: rtl/qld_ctrl.sv
// ----------------------------------------------------------------------------
// qld_ctrl: sequencing controller
// Accepts words, steps the table build and the two lookups per code byte,
// and hands finished distances to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qld_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire qld_pkg::st_t  st,
  output      logic          in_ready,
  output      qld_pkg::cmd_t cmd
);
  import qld_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LOAD   = 7'b0000010,
    S_DRAIN  = 7'b0000100,
    S_RD_LO  = 7'b0001000,
    S_RD_HI  = 7'b0010000,
    S_ACC_HI = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (st.in_is_byte) begin
            state_next = S_RD_LO;
          end else if (st.in_load_ok) begin
            state_next = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd.issue = 1'b1;
        if (st.issue_last) begin
          state_next = S_DRAIN;
        end
      end
      // last square is still in the multiplier; it is written next cycle
      S_DRAIN:  state_next = S_IDLE;
      S_RD_LO: begin
        cmd.rd_lo  = 1'b1;
        state_next = S_RD_HI;
      end
      S_RD_HI: begin
        cmd.rd_hi  = 1'b1;
        state_next = S_ACC_HI;
      end
      S_ACC_HI: begin
        cmd.acc_hi = 1'b1;
        state_next = st.last_byte ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire
